@@ sv/plt_pkg.sv @@
// Shared types and constants for the price ladder best level tracker.
// No dependencies; imported by the tracker and by plt_div.
package plt_pkg;

    localparam int PRICE_W     = 48;
    localparam int OQTY_W      = 32;
    localparam int LQTY_W      = 48;
    localparam int CNT_W       = 16;
    localparam int FILL_W      = 64;
    localparam int TICK_W      = 32;
    localparam int WANT_W      = 5;
    localparam int RAM_W       = CNT_W + LQTY_W;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 168;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_W       = 48;
    localparam int MAX_LEVELS  = 16;
    localparam int NUM_SLOTS_DEF = 1024;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_TOP    = 2'd2,
        OP_FILL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_RANGE      = 2'd1,
        STS_EMPTY_SLOT = 2'd2,
        STS_NONE       = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IS_BID = 2'd0,
        CFG_BASE   = 2'd1,
        CFG_TICK   = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIFF, S_PREP, S_DIV, S_SLOT, S_RD, S_UPD,
        S_MUL, S_ADD, S_WRD, S_WCK, S_FLUSH, S_EMIT
    } state_t;

endpackage

@@ sv/price_ladder_best_level_tracker.sv @@
// Price ladder best level tracker: one side of a book as slots in one RAM.
// Depends on plt_pkg, plt_ram, plt_div.
// Insert and erase with a price at or above the base wait on the slot divider;
// an erase that empties the best slot then walks the slots to find the next best.
// Top levels and fillable walk the RAM slot by slot (read, check).
// Reset: synchronous active-low aresetn; then a clearing pass zeroes every
// RAM slot while s_tready stays low (config is taken as ever).
module price_ladder_best_level_tracker
    import plt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: price[47:0], order_qty[79:48], level_count[84:80], zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation[1:0]
    input  logic [1:0]             s_tuser,
    // m_tdata: level_price[47:0], level_qty[95:48], fill_total[159:96],
    //          best_present[160], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]             m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PRICE_W-1:0]     cfg_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int ACT_W  = SLOT_W + 1;
    localparam int MUL_W  = SLOT_W + TICK_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    // configuration
    logic                is_bid_reg;
    logic [PRICE_W-1:0]  base_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [TICK_W-1:0]   tick_eff;

    // control
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_idx_reg;

    // item
    op_t                 op_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [OQTY_W-1:0]   qty_reg;
    logic [WANT_W-1:0]   want_reg;
    logic [PRICE_W:0]    d_reg;
    logic [SLOT_W-1:0]   slot_reg;

    // ladder summary
    logic [SLOT_W-1:0]   best_reg;
    logic                best_valid_reg;
    logic [ACT_W-1:0]    active_reg;

    // result being built
    status_t             res_status_reg;
    logic [PRICE_W-1:0]  res_price_reg;
    logic [LQTY_W-1:0]   res_qty_reg;
    logic [FILL_W-1:0]   fill_reg;

    // walk
    logic [SLOT_W-1:0]   walk_idx_reg;
    logic [SLOT_W-1:0]   walk_end_reg;
    logic [PRICE_W-1:0]  walk_price_reg;
    logic                rescan_walk_reg;
    logic [WANT_W-1:0]   n_reg;
    logic                held_valid_reg;
    logic [PRICE_W-1:0]  held_price_reg;
    logic [LQTY_W-1:0]   held_qty_reg;
    logic [MUL_W-1:0]    prod_reg;

    // output register
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [PRICE_W-1:0]  m_price_reg;
    logic [LQTY_W-1:0]   m_qty_reg;
    logic [FILL_W-1:0]   m_fill_reg;
    logic                m_best_reg;
    logic                m_last_reg;

    // ram
    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;
    logic [CNT_W-1:0]    rd_cnt;
    logic [LQTY_W-1:0]   rd_qty;

    // divider
    logic                div_start, div_done, div_rem_nz;
    logic [DIV_W-1:0]    div_q;

    // misc comb
    logic                s_acc;
    op_t                 in_op;
    logic [WANT_W-1:0]   in_want, want_clip;
    logic                out_free;
    logic                d_neg, d_zero;
    logic                q_range;
    logic [PRICE_W:0]    fill_lo;
    logic [SLOT_W-1:0]   fill_hi;
    logic                at_end, hit, top_final, top_stall;
    logic [MUL_W-1:0]    mul_a;
    logic [LQTY_W:0]     qsum;
    logic [CNT_W-1:0]    upd_cnt;
    logic [LQTY_W-1:0]   upd_qty;
    logic                upd_emptied;
    logic [ACT_W-1:0]    act_dec;
    logic                out_load, out_last;
    status_t             out_status;
    logic [PRICE_W-1:0]  out_price;
    logic [LQTY_W-1:0]   out_qty;
    logic [FILL_W-1:0]   out_fill;

    assign tick_eff  = (tick_reg == '0) ? TICK_W'(1) : tick_reg;
    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign in_op     = op_t'(s_tuser);
    assign in_want   = s_tdata[84:80];
    assign want_clip = (32'(in_want) > MAX_LEVELS) ? WANT_W'(MAX_LEVELS) : in_want;
    assign out_free  = !m_valid_reg || m_tready;

    assign rd_cnt = ram_rdata[RAM_W-1:LQTY_W];
    assign rd_qty = ram_rdata[LQTY_W-1:0];

    assign d_neg  = d_reg[PRICE_W];
    assign d_zero = d_reg == '0;

    // quotient beyond the ladder
    assign q_range = div_q >= DIV_W'(NUM_SLOTS);
    // bids: lowest slot priced at or above the limit (ceil)
    assign fill_lo = {1'b0, div_q} + (PRICE_W+1)'(div_rem_nz);
    // asks: highest slot priced at or below the limit, clipped
    assign fill_hi = (div_q >= DIV_W'(NUM_SLOTS - 1)) ? SLOT_LAST : SLOT_W'(div_q);

    // walk end: fillable runs to its bound, the others to the ladder edge
    always_comb begin
        if (op_reg == OP_FILL) begin
            at_end = walk_idx_reg == walk_end_reg;
        end else if (is_bid_reg) begin
            at_end = walk_idx_reg == '0;
        end else begin
            at_end = walk_idx_reg == SLOT_LAST;
        end
    end

    assign hit       = rd_cnt != '0;
    assign top_final = hit && (n_reg + 1'b1 == want_reg);
    assign top_stall = (op_reg == OP_TOP) && hit && held_valid_reg && !out_free;

    assign mul_a = (op_reg == OP_TOP) ? MUL_W'(walk_idx_reg) : MUL_W'(slot_reg);

    // slot update for insert and erase
    assign qsum    = {1'b0, rd_qty} + (LQTY_W+1)'(qty_reg);
    assign act_dec = (active_reg != '0) ? active_reg - 1'b1 : active_reg;
    always_comb begin
        upd_emptied = 1'b0;
        if (op_reg == OP_INSERT) begin
            upd_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
            upd_qty = qsum[LQTY_W] ? '1 : qsum[LQTY_W-1:0];
        end else begin
            upd_cnt = rd_cnt - 1'b1;
            upd_qty = (rd_qty > LQTY_W'(qty_reg)) ? rd_qty - LQTY_W'(qty_reg) : '0;
            if (upd_cnt == '0) begin
                upd_qty     = '0;
                upd_emptied = 1'b1;
            end
        end
    end

    // ram port control: clear sweep, slot update, slot reads
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = {upd_cnt, upd_qty};
        ram_re    = 1'b0;
        ram_raddr = walk_idx_reg;
        case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            S_UPD: begin
                // erase of an empty slot leaves the entry as it is
                ram_we = (op_reg == OP_INSERT) || (rd_cnt != '0);
            end
            S_RD: begin
                ram_re    = 1'b1;
                ram_raddr = slot_reg;
            end
            S_WRD: begin
                ram_re = 1'b1;
            end
            default: ;
        endcase
    end

    plt_ram #(
        .WIDTH(RAM_W),
        .DEPTH(NUM_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // start the divider only when a nonnegative offset needs a slot
    always_comb begin
        div_start = 1'b0;
        if (state_reg == S_PREP && !d_neg) begin
            if (op_reg != OP_FILL) begin
                div_start = 1'b1;
            end else if (is_bid_reg) begin
                div_start = !d_zero;
            end else begin
                div_start = 1'b1;
            end
        end
    end

    plt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (d_reg[DIV_W-1:0]),
        .divisor  (tick_eff),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rem_nz)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR: begin
                if (clr_idx_reg == SLOT_LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_TOP:  state_next = (!best_valid_reg || want_clip == '0) ? S_EMIT
                                                                                    : S_MUL;
                        OP_FILL: state_next = best_valid_reg ? S_DIFF : S_EMIT;
                        default: state_next = S_DIFF;
                    endcase
                end
            end
            S_DIFF: state_next = S_PREP;
            S_PREP: begin
                if (div_start) begin
                    state_next = S_DIV;
                end else if (op_reg == OP_FILL && is_bid_reg) begin
                    state_next = S_WRD;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                if (div_done) state_next = S_SLOT;
            end
            S_SLOT: begin
                if (op_reg != OP_FILL) begin
                    state_next = q_range ? S_EMIT : S_RD;
                end else if (is_bid_reg) begin
                    state_next = (fill_lo > (PRICE_W+1)'(best_reg)) ? S_EMIT : S_WRD;
                end else begin
                    state_next = (fill_hi < best_reg) ? S_EMIT : S_WRD;
                end
            end
            S_RD:  state_next = S_UPD;
            S_UPD: state_next = S_MUL;
            S_MUL: state_next = S_ADD;
            S_ADD: begin
                if (op_reg == OP_TOP || (op_reg == OP_ERASE && rescan_walk_reg)) begin
                    state_next = S_WRD;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_WRD: state_next = S_WCK;
            S_WCK: begin
                case (op_reg)
                    OP_TOP: begin
                        if (top_stall) begin
                            state_next = S_WCK;
                        end else if (top_final || at_end) begin
                            // the last level found is held and leaves as the final beat
                            state_next = S_FLUSH;
                        end else begin
                            state_next = S_WRD;
                        end
                    end
                    OP_ERASE: state_next = (hit || at_end) ? S_EMIT : S_WRD;
                    default:  state_next = at_end ? S_EMIT : S_WRD;
                endcase
            end
            S_FLUSH: begin
                if (out_free) state_next = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result beat selection
    always_comb begin
        out_load   = 1'b0;
        out_status = res_status_reg;
        out_price  = res_price_reg;
        out_qty    = res_qty_reg;
        out_fill   = fill_reg;
        out_last   = 1'b1;
        case (state_reg)
            S_EMIT: begin
                out_load = out_free;
            end
            S_WCK: begin
                if (op_reg == OP_TOP && hit && !top_stall && held_valid_reg) begin
                    // a later level exists: the held one is not final
                    out_load   = 1'b1;
                    out_status = STS_OK;
                    out_price  = held_price_reg;
                    out_qty    = held_qty_reg;
                    out_fill   = '0;
                    out_last   = 1'b0;
                end
            end
            S_FLUSH: begin
                out_load = out_free;
                out_fill = '0;
                if (held_valid_reg) begin
                    out_status = STS_OK;
                    out_price  = held_price_reg;
                    out_qty    = held_qty_reg;
                end else begin
                    out_status = STS_NONE;
                    out_price  = '0;
                    out_qty    = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            clr_idx_reg    <= '0;
            is_bid_reg     <= 1'b0;
            base_reg       <= '0;
            tick_reg       <= TICK_W'(1);
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            active_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == S_CLR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end

            // registers must be written only while idle; the block itself does not enforce this, so no guard here
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_IS_BID: is_bid_reg <= cfg_data[0];
                    CFG_BASE:   base_reg   <= cfg_data;
                    CFG_TICK:   tick_reg   <= cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            // insert and erase move the best slot and the active count
            if (state_reg == S_UPD) begin
                if (op_reg == OP_INSERT) begin
                    if (rd_cnt == '0) active_reg <= active_reg + 1'b1;
                    if (!best_valid_reg ||
                        (is_bid_reg ? (slot_reg > best_reg) : (slot_reg < best_reg))) begin
                        best_reg       <= slot_reg;
                        best_valid_reg <= 1'b1;
                    end
                end else if (rd_cnt != '0 && upd_emptied) begin
                    active_reg <= act_dec;
                    if (best_valid_reg && slot_reg == best_reg) begin
                        // drop the best; the rescan restores it on a hit
                        best_valid_reg <= 1'b0;
                    end
                end
            end

            if (state_reg == S_WCK && op_reg == OP_ERASE && hit) begin
                best_reg       <= walk_idx_reg;
                best_valid_reg <= 1'b1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // payload
        if (out_load) begin
            m_status_reg <= out_status;
            m_price_reg  <= out_price;
            m_qty_reg    <= out_qty;
            m_fill_reg   <= out_fill;
            m_best_reg   <= best_valid_reg;
            m_last_reg   <= out_last;
        end

        case (state_reg)
            S_IDLE: begin
                op_reg          <= in_op;
                price_reg       <= s_tdata[47:0];
                qty_reg         <= s_tdata[79:48];
                want_reg        <= want_clip;
                res_status_reg  <= (in_op == OP_TOP || in_op == OP_FILL) ? STS_NONE : STS_OK;
                res_price_reg   <= '0;
                res_qty_reg     <= '0;
                fill_reg        <= '0;
                n_reg           <= '0;
                held_valid_reg  <= 1'b0;
                rescan_walk_reg <= 1'b0;
                walk_idx_reg    <= best_reg;
                if (in_op == OP_FILL && best_valid_reg) res_status_reg <= STS_OK;
            end
            S_DIFF: begin
                d_reg <= {price_reg[PRICE_W-1], price_reg} - {base_reg[PRICE_W-1], base_reg};
            end
            S_PREP: begin
                if (d_neg && op_reg != OP_FILL) begin
                    res_status_reg <= STS_RANGE;
                end
                // bid limit at or below the base: the walk starts at slot zero
                walk_idx_reg <= '0;
                walk_end_reg <= best_reg;
            end
            S_SLOT: begin
                slot_reg <= SLOT_W'(div_q);
                if (op_reg != OP_FILL) begin
                    if (q_range) res_status_reg <= STS_RANGE;
                end else if (is_bid_reg) begin
                    walk_idx_reg <= SLOT_W'(fill_lo);
                    walk_end_reg <= best_reg;
                end else begin
                    walk_idx_reg <= best_reg;
                    walk_end_reg <= fill_hi;
                end
            end
            S_UPD: begin
                if (op_reg == OP_ERASE && rd_cnt == '0) begin
                    res_status_reg <= STS_EMPTY_SLOT;
                    res_qty_reg    <= rd_qty;
                end else begin
                    res_qty_reg <= upd_qty;
                end
                // rescan away from the emptied best slot unless at the edge
                if (op_reg == OP_ERASE && rd_cnt != '0 && upd_emptied &&
                    best_valid_reg && slot_reg == best_reg && act_dec != '0) begin
                    rescan_walk_reg <= is_bid_reg ? (slot_reg != '0) : (slot_reg != SLOT_LAST);
                end
                walk_idx_reg <= is_bid_reg ? slot_reg - 1'b1 : slot_reg + 1'b1;
            end
            S_MUL: begin
                prod_reg <= mul_a * MUL_W'(tick_eff);
            end
            S_ADD: begin
                res_price_reg  <= base_reg + PRICE_W'(prod_reg);
                walk_price_reg <= base_reg + PRICE_W'(prod_reg);
            end
            S_WCK: begin
                if (op_reg == OP_FILL) begin
                    fill_reg <= fill_reg + FILL_W'(rd_qty);
                    walk_idx_reg <= walk_idx_reg + 1'b1;
                end else if (op_reg == OP_ERASE) begin
                    walk_idx_reg <= is_bid_reg ? walk_idx_reg - 1'b1 : walk_idx_reg + 1'b1;
                end else if (!top_stall) begin
                    if (hit) begin
                        n_reg          <= n_reg + 1'b1;
                        held_valid_reg <= 1'b1;
                        held_price_reg <= walk_price_reg;
                        held_qty_reg   <= rd_qty;
                    end
                    if (is_bid_reg) begin
                        walk_idx_reg   <= walk_idx_reg - 1'b1;
                        walk_price_reg <= walk_price_reg - PRICE_W'(tick_eff);
                    end else begin
                        walk_idx_reg   <= walk_idx_reg + 1'b1;
                        walk_price_reg <= walk_price_reg + PRICE_W'(tick_eff);
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_best_reg, m_fill_reg, m_qty_reg, m_price_reg};

endmodule

@@ sv/plt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/plt_div.sv @@
// Restoring divider, one quotient bit per cycle, for price-to-slot mapping.
// Depends on plt_pkg.
module plt_div
    import plt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [TICK_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient,
    output logic              rem_nz
);

    localparam int CW = $clog2(DIV_W);

    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] dvs_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [TICK_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? TICK_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[TICK_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;

endmodule
